### hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define AST_RUN(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("check failed");

// property checked at every edge, reset included
`define AST_ALL(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("check failed");

`endif

### hdl/frlm_pkg.sv
// shared types, constants and helpers of the framed rms and peak level meter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package frlm_pkg;

    localparam int NUM_CHANNELS_DEF = 2;
    localparam int CAPACITY_DEF     = 64;

    localparam int SUM_W   = 45;
    localparam int PWR_W   = 33;
    localparam int FILL_W  = 13;
    localparam int LVL_W   = 16;
    localparam int TICK_W  = 32;
    localparam int SMP_W   = 16;
    localparam int CH_W    = 3;
    localparam int CFG_W   = 13;
    localparam int OPR_W   = 46;
    localparam int ROOT_W  = 23;
    localparam int SREM_W  = 25;

    localparam logic [FILL_W-1:0] FRAME_LEN_RST = 13'd1024;
    localparam logic [FILL_W-1:0] FRAME_LEN_MAX = 13'd4096;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_FRAME_LEN = 1'b0;
    localparam logic REG_CPLX_MODE = 1'b1;

    typedef struct packed {
        logic                     opcode;
        logic [CH_W-1:0]          channel;
        logic signed [SMP_W-1:0]  sample_re;
        logic signed [SMP_W-1:0]  sample_im;
        logic [TICK_W-1:0]        tick_value;
        logic [TICK_W-1:0]        peak_from_tick;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ1,
        S_SQ2,
        S_DIV,
        S_ROOT,
        S_CLOSE,
        S_QRD,
        S_QST,
        S_QCH,
        S_QDAT,
        S_OUT
    } t_state;

    function automatic logic not_before(input logic [TICK_W-1:0] a,
                                        input logic [TICK_W-1:0] b);
        logic [TICK_W-1:0] d;
        d = a - b;
        return ~d[TICK_W-1];
    endfunction

endpackage

`default_nettype wire

### hdl/frlm_front.sv
// front part: accepts items, drops pushes on absent channels, two-entry queue
// depends on frlm_pkg
`timescale 1ns / 1ps
`default_nettype none

module frlm_front #(
    parameter int NUM_CHANNELS = frlm_pkg::NUM_CHANNELS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  frlm_pkg::t_item      i_item,
    input  wire                  i_pop,
    output frlm_pkg::t_queue_head o_head
);
    import frlm_pkg::*;

    t_item       r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        keep;
    logic        push_q;
    logic        pop_q;

    assign o_stall = (r_cnt == 2'd2);
    assign keep    = (i_item.opcode == OP_QUERY) ||
                     ({1'b0, i_item.channel} < (CH_W + 1)'(NUM_CHANNELS));
    assign push_q  = i_valid && !o_stall && keep;
    assign pop_q   = i_pop && (r_cnt != 2'd0);

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push_q) begin
            r_q[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_q) begin
                r_wp <= ~r_wp;
            end
            if (pop_q) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push_q} - {1'b0, pop_q};
        end
    end

endmodule

`default_nettype wire

### hdl/frlm_back.sv
// back part: power accumulation, frame close with divider and root unit,
// history memories, query walk and output register; depends on frlm_pkg
`timescale 1ns / 1ps
`default_nettype none

module frlm_back #(
    parameter int NUM_CHANNELS = frlm_pkg::NUM_CHANNELS_DEF,
    parameter int CAPACITY     = frlm_pkg::CAPACITY_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  frlm_pkg::t_queue_head        i_head,
    output logic                         o_pop,
    input  wire [frlm_pkg::FILL_W-1:0]   i_frame_len,
    input  wire                          i_cplx_mode,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [frlm_pkg::CH_W-1:0]    o_result_channel,
    output logic [frlm_pkg::LVL_W-1:0]   o_level_rms,
    output logic [frlm_pkg::LVL_W-1:0]   o_level_peak,
    output logic                         o_found,
    output logic                         o_last
);
    import frlm_pkg::*;

    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam int LVD  = CAPACITY * NUM_CHANNELS;
    localparam int LAW  = (LVD > 1) ? $clog2(LVD) : 1;
    localparam int CW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    t_state r_state, n_state;

    t_item               r_it;
    logic [31:0]         r_p;
    logic [SUM_W-1:0]    r_sum [NUM_CHANNELS];
    logic [PWR_W-1:0]    r_pwr [NUM_CHANNELS];
    logic [FILL_W-1:0]   r_fill;
    logic [IW-1:0]       r_wptr;
    logic [CNTW-1:0]     r_count;
    logic [CW-1:0]       r_c;
    logic [5:0]          r_step;
    logic [SUM_W-1:0]    r_quo;
    logic [FILL_W-1:0]   r_rem;
    logic [OPR_W-1:0]    r_op;
    logic [SREM_W-1:0]   r_srem;
    logic [ROOT_W-1:0]   r_root;
    logic                r_sel_pk;
    logic [IW-1:0]       r_qidx;
    logic [CNTW-1:0]     r_i;
    logic                r_found;
    logic                r_ld_rms;
    logic                r_qual;
    logic [LVL_W-1:0]    r_lrms [NUM_CHANNELS];
    logic [LVL_W-1:0]    r_lpk  [NUM_CHANNELS];
    logic                r_ov;
    logic [CH_W-1:0]     r_och;
    logic [LVL_W-1:0]    r_orms;
    logic [LVL_W-1:0]    r_opk;
    logic                r_ofound;
    logic                r_olast;

    logic [LVL_W-1:0]    rms_mem [LVD];
    logic [LVL_W-1:0]    pk_mem  [LVD];
    logic [TICK_W-1:0]   st_mem  [CAPACITY];
    logic [LVL_W-1:0]    r_rms_rd;
    logic [LVL_W-1:0]    r_pk_rd;
    logic [TICK_W-1:0]   r_st_rd;

    // datapath helpers
    logic [CW-1:0]       ich;
    logic [31:0]         sq_re;
    logic [31:0]         sq_im;
    logic [PWR_W-1:0]    pwr;
    logic [SUM_W:0]      sum_ext;
    logic [FILL_W-1:0]   fill_inc;
    logic [FILL_W-1:0]   eff_len;
    logic                frame_end;
    logic [FILL_W:0]     rem_sh;
    logic                rem_ge;
    logic [SREM_W-1:0]   srem_sh;
    logic [SREM_W-1:0]   trial;
    logic                srem_ge;
    logic [ROOT_W-1:0]   root_nx;
    logic [LVL_W-1:0]    root_sat;
    logic                root_done;
    logic                div_done;
    logic                last_ch;
    logic                out_free;
    logic                walk_end;
    logic                hit;
    logic                qual;
    logic [IW-1:0]       wptr_nx;
    logic [IW-1:0]       newest;
    logic [IW-1:0]       qidx_nx;
    logic [LAW-1:0]      wr_addr;
    logic [LAW-1:0]      rd_addr;
    logic                rms_we;
    logic                pk_we;
    logic                st_we;

    assign ich      = r_it.channel[CW-1:0];
    assign sq_re    = 32'(r_it.sample_re * r_it.sample_re);
    assign sq_im    = 32'(r_it.sample_im * r_it.sample_im);
    assign pwr      = {1'b0, r_p} + (i_cplx_mode ? {1'b0, sq_im} : '0);
    assign sum_ext  = {1'b0, r_sum[ich]} + (SUM_W + 1)'(pwr);
    assign fill_inc = r_fill + 1'b1;
    assign eff_len  = (i_frame_len == '0) ? FILL_W'(1) :
                      ((i_frame_len > FRAME_LEN_MAX) ? FRAME_LEN_MAX : i_frame_len);
    assign last_ch  = (r_it.channel == CH_W'(NUM_CHANNELS - 1));
    assign frame_end = last_ch && (fill_inc >= eff_len);

    assign rem_sh   = {r_rem, r_quo[SUM_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, r_fill});
    assign div_done = (r_step == 6'(SUM_W - 1));

    assign srem_sh  = {r_srem[SREM_W-3:0], r_op[OPR_W-1 -: 2]};
    assign trial    = {r_root, 2'b01};
    assign srem_ge  = (srem_sh >= trial);
    assign root_nx  = {r_root[ROOT_W-2:0], srem_ge};
    assign root_sat = (root_nx[ROOT_W-1:LVL_W] != '0) ? '1 : root_nx[LVL_W-1:0];
    assign root_done = (r_step == 6'(ROOT_W - 1));

    assign wptr_nx  = (r_wptr == IW'(CAPACITY - 1)) ? '0 : r_wptr + 1'b1;
    assign newest   = (r_wptr == '0) ? IW'(CAPACITY - 1) : r_wptr - 1'b1;
    assign qidx_nx  = (r_qidx == '0) ? IW'(CAPACITY - 1) : r_qidx - 1'b1;
    assign wr_addr  = LAW'(r_wptr) * LAW'(NUM_CHANNELS) + LAW'(r_c);
    assign rd_addr  = LAW'(r_qidx) * LAW'(NUM_CHANNELS) + LAW'(r_c);

    assign hit      = not_before(r_it.tick_value, r_st_rd);
    assign qual     = not_before(r_st_rd, r_it.peak_from_tick);
    assign walk_end = ((r_i + 1'b1) == r_count);
    assign out_free = !r_ov || !i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    if (i_head.item.opcode == OP_PUSH) begin
                        n_state = S_SQ1;
                    end else if (r_count == '0) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_QRD;
                    end
                end
            end
            S_SQ1:   n_state = S_SQ2;
            S_SQ2:   n_state = frame_end ? S_DIV : S_IDLE;
            S_DIV:   n_state = div_done ? S_ROOT : S_DIV;
            S_ROOT: begin
                if (root_done && r_sel_pk) begin
                    n_state = (r_c == CW'(NUM_CHANNELS - 1)) ? S_CLOSE : S_DIV;
                end
            end
            S_CLOSE: n_state = S_IDLE;
            S_QRD:   n_state = S_QST;
            S_QST: begin
                if (!hit) begin
                    n_state = walk_end ? S_OUT : S_QRD;
                end else if (!r_found || qual) begin
                    n_state = S_QCH;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_QCH:   n_state = S_QDAT;
            S_QDAT: begin
                if (r_c == CW'(NUM_CHANNELS - 1)) begin
                    n_state = (r_qual && !walk_end) ? S_QRD : S_OUT;
                end else begin
                    n_state = S_QCH;
                end
            end
            S_OUT: begin
                if (out_free && (r_c == CW'(NUM_CHANNELS - 1))) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_pop  = 1'b0;
        rms_we = 1'b0;
        pk_we  = 1'b0;
        st_we  = 1'b0;
        unique case (r_state)
            S_IDLE:  o_pop = i_head.valid;
            S_ROOT: begin
                rms_we = root_done && !r_sel_pk;
                pk_we  = root_done && r_sel_pk;
            end
            S_CLOSE: st_we = 1'b1;
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // history memories
    always_ff @(posedge i_clk) begin
        if (rms_we) begin
            rms_mem[wr_addr] <= root_sat;
        end
        if (pk_we) begin
            pk_mem[wr_addr] <= root_sat;
        end
        if (st_we) begin
            st_mem[r_wptr] <= r_it.tick_value;
        end
        r_rms_rd <= rms_mem[rd_addr];
        r_pk_rd  <= pk_mem[rd_addr];
        r_st_rd  <= st_mem[r_qidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_wptr  <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_sum[k] <= '0;
                r_pwr[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (!i_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_it     <= i_head.item;
                    r_qidx   <= newest;
                    r_i      <= '0;
                    r_c      <= '0;
                    r_found  <= 1'b0;
                    for (int k = 0; k < NUM_CHANNELS; k++) begin
                        r_lrms[k] <= '0;
                        r_lpk[k]  <= '0;
                    end
                end
                S_SQ1: r_p <= sq_re;
                S_SQ2: begin
                    r_sum[ich] <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
                    if (pwr > r_pwr[ich]) begin
                        r_pwr[ich] <= pwr;
                    end
                    if (last_ch) begin
                        r_fill <= fill_inc;
                    end
                    r_c    <= '0;
                    r_step <= '0;
                    r_rem  <= '0;
                    r_quo  <= (ich == '0) ? sum_ext[SUM_W-1:0] : r_sum[0];
                    if (sum_ext[SUM_W] && ich == '0) begin
                        r_quo <= '1;
                    end
                end
                S_DIV: begin
                    r_rem  <= rem_ge ? FILL_W'(rem_sh - {1'b0, r_fill}) : rem_sh[FILL_W-1:0];
                    r_quo  <= {r_quo[SUM_W-2:0], rem_ge};
                    r_step <= r_step + 1'b1;
                    if (div_done) begin
                        r_op     <= {1'b0, r_quo[SUM_W-2:0], rem_ge};
                        r_srem   <= '0;
                        r_root   <= '0;
                        r_step   <= '0;
                        r_sel_pk <= 1'b0;
                    end
                end
                S_ROOT: begin
                    r_op   <= {r_op[OPR_W-3:0], 2'b00};
                    r_srem <= srem_ge ? srem_sh - trial : srem_sh;
                    r_root <= root_nx;
                    r_step <= r_step + 1'b1;
                    if (root_done) begin
                        r_srem <= '0;
                        r_root <= '0;
                        r_step <= '0;
                        if (!r_sel_pk) begin
                            r_op     <= OPR_W'(r_pwr[r_c]);
                            r_sel_pk <= 1'b1;
                        end else begin
                            r_c   <= r_c + 1'b1;
                            r_rem <= '0;
                            r_quo <= r_sum[r_c + 1'b1];
                        end
                    end
                end
                S_CLOSE: begin
                    r_wptr <= wptr_nx;
                    if (r_count != CNTW'(CAPACITY)) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_fill <= '0;
                    for (int k = 0; k < NUM_CHANNELS; k++) begin
                        r_sum[k] <= '0;
                        r_pwr[k] <= '0;
                    end
                end
                S_QRD: begin
                    r_c <= '0;
                end
                S_QST: begin
                    r_c <= '0;
                    if (!hit) begin
                        r_i    <= r_i + 1'b1;
                        r_qidx <= qidx_nx;
                    end else begin
                        r_ld_rms <= !r_found;
                        r_qual   <= qual;
                        r_found  <= 1'b1;
                    end
                end
                S_QCH: begin
                    r_i <= r_i;
                end
                S_QDAT: begin
                    if (r_ld_rms) begin
                        r_lrms[r_c] <= r_rms_rd;
                    end
                    if (r_qual && (r_pk_rd > r_lpk[r_c])) begin
                        r_lpk[r_c] <= r_pk_rd;
                    end
                    if (r_c == CW'(NUM_CHANNELS - 1)) begin
                        r_c    <= '0;
                        r_i    <= r_i + 1'b1;
                        r_qidx <= qidx_nx;
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ov     <= 1'b1;
                        r_och    <= CH_W'(r_c);
                        r_orms   <= r_lrms[r_c];
                        r_opk    <= r_lpk[r_c];
                        r_ofound <= r_found;
                        r_olast  <= (r_c == CW'(NUM_CHANNELS - 1));
                        r_c      <= r_c + 1'b1;
                    end
                end
                default: begin
                    r_c <= r_c;
                end
            endcase
        end
    end

    assign o_valid          = r_ov;
    assign o_result_channel = r_och;
    assign o_level_rms      = r_orms;
    assign o_level_peak     = r_opk;
    assign o_found          = r_ofound;
    assign o_last           = r_olast;

endmodule

`default_nettype wire

### hdl/framed_rms_peak_level_meter.sv
// push: goes from acceptance through the queue and the squarer; a frame end adds
// per channel a division and the rms and peak roots in the divider and root unit
// query: walks frames newest first, reading stamps and visited frames' levels,
// then one result per cycle unless stalled; one item in the back part at a time
// synchronous active-low reset clears sums, fill, ring pointers and handshakes
// top level; depends on frlm_pkg, frlm_front, frlm_back
`timescale 1ns / 1ps
`default_nettype none

module framed_rms_peak_level_meter #(
    parameter int NUM_CHANNELS = frlm_pkg::NUM_CHANNELS_DEF,
    parameter int CAPACITY     = frlm_pkg::CAPACITY_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire                          i_cfg_idx,
    input  wire [frlm_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire                          i_opcode,
    input  wire [frlm_pkg::CH_W-1:0]     i_channel,
    input  wire signed [frlm_pkg::SMP_W-1:0] i_sample_re,
    input  wire signed [frlm_pkg::SMP_W-1:0] i_sample_im,
    input  wire [frlm_pkg::TICK_W-1:0]   i_tick_value,
    input  wire [frlm_pkg::TICK_W-1:0]   i_peak_from_tick,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [frlm_pkg::CH_W-1:0]    o_result_channel,
    output logic [frlm_pkg::LVL_W-1:0]   o_level_rms,
    output logic [frlm_pkg::LVL_W-1:0]   o_level_peak,
    output logic                         o_found,
    output logic                         o_last
);
    import frlm_pkg::*;

    logic [FILL_W-1:0] r_frame_len;
    logic              r_cplx_mode;
    t_item             item;
    t_queue_head       head;
    logic              pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len <= FRAME_LEN_RST;
            r_cplx_mode <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_LEN: r_frame_len <= i_cfg_data;
                REG_CPLX_MODE: r_cplx_mode <= i_cfg_data[0];
                default:       r_cplx_mode <= r_cplx_mode;
            endcase
        end
    end

    assign item.opcode         = i_opcode;
    assign item.channel        = i_channel;
    assign item.sample_re      = i_sample_re;
    assign item.sample_im      = i_sample_im;
    assign item.tick_value     = i_tick_value;
    assign item.peak_from_tick = i_peak_from_tick;

    frlm_front #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (item),
        .i_pop   (pop),
        .o_head  (head)
    );

    frlm_back #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .CAPACITY    (CAPACITY)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .o_pop            (pop),
        .i_frame_len      (r_frame_len),
        .i_cplx_mode      (r_cplx_mode),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result_channel (o_result_channel),
        .o_level_rms      (o_level_rms),
        .o_level_peak     (o_level_peak),
        .o_found          (o_found),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire

### hdl/frlm_chk.sv
// port checker for the level meter and its bind to the top level
// depends on frlm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module frlm_chk #(
    parameter int NUM_CHANNELS = frlm_pkg::NUM_CHANNELS_DEF
) (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          o_valid,
    input wire                          i_stall,
    input wire [frlm_pkg::CH_W-1:0]     o_result_channel,
    input wire [frlm_pkg::LVL_W-1:0]    o_level_rms,
    input wire [frlm_pkg::LVL_W-1:0]    o_level_peak,
    input wire                          o_found,
    input wire                          o_last
);
    import frlm_pkg::*;

    `AST_ALL(a_rst_idle, i_clk, !i_rst_n |=> !o_valid)
    `AST_RUN(a_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_level_rms) && $stable(o_level_peak))
    `AST_RUN(a_none_zero, i_clk, i_rst_n, o_valid && !o_found |-> o_level_rms == '0 && o_level_peak == '0)
    `AST_RUN(a_last_ch, i_clk, i_rst_n, o_valid |-> o_last == (o_result_channel == CH_W'(NUM_CHANNELS - 1)))

endmodule

bind framed_rms_peak_level_meter frlm_chk #(
    .NUM_CHANNELS(NUM_CHANNELS)
) u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_result_channel (o_result_channel),
    .o_level_rms      (o_level_rms),
    .o_level_peak     (o_level_peak),
    .o_found          (o_found),
    .o_last           (o_last)
);

`default_nettype wire

### verif/tb_framed_rms_peak_level_meter.sv
// testbench for framed_rms_peak_level_meter: directed and random pushes and queries
// with bursty input, patterned output stall, and a level predictor in a scoreboard class
// depends on frlm_pkg and the block rtl
`timescale 1ns / 1ps

module tb_framed_rms_peak_level_meter;
    import frlm_pkg::*;

    localparam int NCH = NUM_CHANNELS_DEF;
    localparam int CAP = CAPACITY_DEF;
    localparam longint unsigned SUM_SAT = (64'd1 << SUM_W) - 1;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE = 1000;

    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic [LVL_W-1:0] rms;
        logic [LVL_W-1:0] peak;
        logic             found;
        logic             last;
    } t_level;

    class level_scoreboard;
        longint unsigned  acc_sum[NCH];
        longint unsigned  acc_peak[NCH];
        int unsigned      fill;
        logic [LVL_W-1:0] hist_rms[CAP*NCH];
        logic [LVL_W-1:0] hist_peak[CAP*NCH];
        logic [31:0]      hist_stamp[CAP];
        int unsigned      head;
        int unsigned      used;
        int unsigned      frame_len;
        bit               cplx;
        t_level           levels_due[$];
        int               errors;

        function new();
            foreach (acc_sum[c]) begin
                acc_sum[c] = 0;
                acc_peak[c] = 0;
            end
            fill = 0;
            head = 0;
            used = 0;
            frame_len = FRAME_LEN_RST;
            cplx = 1;
            errors = 0;
        endfunction

        function void set_reg(logic idx, logic [CFG_W-1:0] val);
            if (idx == REG_FRAME_LEN) frame_len = val;
            else cplx = val[0];
        endfunction

        function logic [LVL_W-1:0] int_root(longint unsigned v);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= v) r = t;
            end
            return (r > 65535) ? 16'hFFFF : r[15:0];
        endfunction

        function bit at_or_after(logic [31:0] a, logic [31:0] b);
            logic [31:0] d;
            d = a - b;
            return !d[31];
        endfunction

        function void store_frame(logic [31:0] stamp);
            int unsigned slot;
            longint unsigned n;
            if (used < CAP) begin
                slot = (head + used) % CAP;
                used++;
            end else begin
                slot = head;
                head = (head + 1) % CAP;
            end
            n = (fill != 0) ? fill : 1;
            for (int c = 0; c < NCH; c++) begin
                hist_rms[slot*NCH+c] = int_root(acc_sum[c] / n);
                hist_peak[slot*NCH+c] = int_root(acc_peak[c]);
                acc_sum[c] = 0;
                acc_peak[c] = 0;
            end
            hist_stamp[slot] = stamp;
            fill = 0;
        endfunction

        function void note_input(t_item it);
            longint re;
            longint im;
            longint unsigned p;
            int unsigned eff;
            logic [LVL_W-1:0] rms[NCH];
            logic [LVL_W-1:0] pk[NCH];
            bit hit;
            int unsigned slot;
            logic [31:0] st;
            t_level lv;
            if (it.opcode == OP_PUSH) begin
                if (it.channel >= NCH) return;
                re = it.sample_re;
                im = it.sample_im;
                p = re * re;
                if (cplx) p += im * im;
                acc_sum[it.channel] = (acc_sum[it.channel] > SUM_SAT - p) ?
                                      SUM_SAT : acc_sum[it.channel] + p;
                if (p > acc_peak[it.channel]) acc_peak[it.channel] = p;
                if (it.channel == NCH - 1) begin
                    fill++;
                    eff = (frame_len < 1) ? 1 : (frame_len > 4096) ? 4096 : frame_len;
                    if (fill >= eff) store_frame(it.tick_value);
                end
            end else begin
                hit = 0;
                foreach (rms[c]) begin
                    rms[c] = 0;
                    pk[c] = 0;
                end
                for (int i = 0; i < used; i++) begin
                    slot = (head + used - 1 - i) % CAP;
                    st = hist_stamp[slot];
                    if (!at_or_after(it.tick_value, st)) continue;
                    if (!hit) begin
                        for (int c = 0; c < NCH; c++) rms[c] = hist_rms[slot*NCH+c];
                        hit = 1;
                    end
                    if (!at_or_after(st, it.peak_from_tick)) break;
                    for (int c = 0; c < NCH; c++)
                        if (hist_peak[slot*NCH+c] > pk[c]) pk[c] = hist_peak[slot*NCH+c];
                end
                for (int c = 0; c < NCH; c++) begin
                    lv.ch = c;
                    lv.rms = rms[c];
                    lv.peak = pk[c];
                    lv.found = hit;
                    lv.last = (c == NCH - 1);
                    levels_due.push_back(lv);
                end
            end
        endfunction

        function void check_result(t_level got);
            t_level want;
            if (levels_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result: %p", got);
                return;
            end
            want = levels_due.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic                    i_cfg_idx;
    logic [CFG_W-1:0]        i_cfg_data;
    logic                    i_valid;
    logic                    o_stall;
    logic                    i_opcode;
    logic [CH_W-1:0]         i_channel;
    logic signed [SMP_W-1:0] i_sample_re;
    logic signed [SMP_W-1:0] i_sample_im;
    logic [TICK_W-1:0]       i_tick_value;
    logic [TICK_W-1:0]       i_peak_from_tick;
    logic                    o_valid;
    logic                    i_stall;
    logic [CH_W-1:0]         o_result_channel;
    logic [LVL_W-1:0]        o_level_rms;
    logic [LVL_W-1:0]        o_level_peak;
    logic                    o_found;
    logic                    o_last;

    framed_rms_peak_level_meter u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_opcode(i_opcode), .i_channel(i_channel),
        .i_sample_re(i_sample_re), .i_sample_im(i_sample_im),
        .i_tick_value(i_tick_value), .i_peak_from_tick(i_peak_from_tick),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_result_channel(o_result_channel), .o_level_rms(o_level_rms),
        .o_level_peak(o_level_peak), .o_found(o_found), .o_last(o_last)
    );

    level_scoreboard levels = new();
    int          burst_left = 0;
    int          idle_cycles = 0;
    int          stall_phase = 0;
    int          stall_mode = 0;
    int          next_ch = 0;
    logic [31:0] now_tick = 32'hFFFF_FF00;

    always #5 i_clk = ~i_clk;

    // receiver stall pattern, with a style chosen at random from four
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 48 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= stall_phase[0];
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            levels.check_result({o_result_channel, o_level_rms, o_level_peak, o_found, o_last});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_item(t_item it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_opcode <= it.opcode;
        i_channel <= it.channel;
        i_sample_re <= it.sample_re;
        i_sample_im <= it.sample_im;
        i_tick_value <= it.tick_value;
        i_peak_from_tick <= it.peak_from_tick;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        levels.note_input(it);
    endtask

    task automatic push(logic [2:0] ch, logic [15:0] re, logic [15:0] im, logic [31:0] tk);
        t_item it;
        it = '{OP_PUSH, ch, re, im, tk, $urandom};
        send_item(it);
    endtask

    task automatic query(logic [31:0] tk, logic [31:0] from);
        t_item it;
        it = '{OP_QUERY, 3'($urandom), 16'($urandom), 16'($urandom), tk, from};
        send_item(it);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (levels.levels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        levels.set_reg(idx, val);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 7) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_random(int n, int q_pct);
        int r;
        logic [31:0] tk;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < q_pct) begin
                if ($urandom_range(0, 6) == 0) begin
                    query($urandom, $urandom);
                end else begin
                    tk = now_tick - $urandom_range(0, 30);
                    query(tk, tk - $urandom_range(0, 50));
                end
            end else if (r < q_pct + 8) begin
                push($urandom_range(NCH, 7), rand_sample(), rand_sample(), $urandom);
            end else if (r < q_pct + 12) begin
                push(0, rand_sample(), rand_sample(), $urandom);
            end else begin
                if (next_ch == NCH - 1) now_tick += $urandom_range(1, 5);
                push(next_ch, rand_sample(), rand_sample(), now_tick);
                next_ch = (next_ch + 1) % NCH;
            end
        end
    endtask

    initial begin
        logic [31:0] t0;
        i_clk = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = REG_FRAME_LEN;
        i_cfg_data = '0;
        i_valid = 0;
        i_stall = 0;
        i_opcode = OP_PUSH;
        i_channel = '0;
        i_sample_re = '0;
        i_sample_im = '0;
        i_tick_value = '0;
        i_peak_from_tick = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part with one-instant frames around the tick wrap
        t0 = 32'hFFFF_FFF8;
        write_reg(REG_FRAME_LEN, 13'd1);
        write_reg(REG_CPLX_MODE, 13'd1);
        query(32'd5, 32'd0);
        push(0, 16'h8000, 16'h8000, t0);
        push(1, 16'h7FFF, 16'h0000, t0);
        push(2, 16'h0001, 16'h0001, t0);
        push(7, 16'hFFFF, 16'hFFFF, t0);
        push(0, 16'h0000, 16'h7FFF, t0 + 16);
        push(1, 16'hFFFF, 16'h8000, t0 + 16);
        push(0, 16'h1234, 16'hFFFF, t0 + 32);
        push(0, 16'h8000, 16'h0000, t0 + 32);
        push(1, 16'h0000, 16'h0000, t0 + 32);
        query(t0 + 16, t0);
        query(t0 + 40, t0 + 33);
        query(t0 - 100, t0 - 200);
        query(t0 + 100, t0 - 1);
        query(32'hFFFF_FFFF, 32'h0000_0000);
        query(32'h0000_0000, 32'hFFFF_FFFF);
        drain();

        // real mode, frame length below range
        write_reg(REG_FRAME_LEN, 13'd0);
        write_reg(REG_CPLX_MODE, 13'd0);
        push(0, 16'h8000, 16'h7FFF, now_tick);
        push(1, 16'h7FFF, 16'h8000, now_tick);
        query(now_tick, now_tick);
        run_random(6, 20);
        drain();

        // frame length above range, then shortened mid frame
        write_reg(REG_FRAME_LEN, 13'h1FFF);
        write_reg(REG_CPLX_MODE, 13'd1);
        run_random(6, 10);
        drain();
        write_reg(REG_FRAME_LEN, 13'd3);
        run_random(10, 20);
        drain();

        write_reg(REG_FRAME_LEN, 13'd4096);
        run_random(4, 25);
        drain();

        // enough one-instant frames to wrap the history
        write_reg(REG_FRAME_LEN, 13'd1);
        write_reg(REG_CPLX_MODE, 13'd0);
        for (int k = 0; k < 66; k++) begin
            now_tick += $urandom_range(1, 5);
            push(3'(NCH - 1), rand_sample(), rand_sample(), now_tick);
        end
        run_random(6, 40);
        drain();
        write_reg(REG_FRAME_LEN, 13'd2);
        write_reg(REG_CPLX_MODE, 13'd1);
        run_random(8, 30);
        drain();

        levels.errors += levels.levels_due.size();
        if (levels.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
